[design/clf_pkg.sv]
// ---------------------------------------------------------------------------
// clf_pkg
// Shared types, constants and register codes of the clip fade / crossfade
// gain block.
// ---------------------------------------------------------------------------
`default_nettype none

package clf_pkg;

	localparam int SAMPLE_BITS     = 24;
	localparam int GAIN_BITS       = 20;
	localparam int GAIN_FRAC_BITS  = 16;
	localparam int TRIG_FRAC       = 16;
	localparam int OFFSET_BITS     = 32;
	localparam int SINE_DEPTH_DEF  = 1024;

	localparam int CFG_IDX_BITS    = 3;
	localparam int CFG_DATA_BITS   = 32;

	localparam int DIV_QBITS       = 17;
	localparam int DIV_IN_W        = OFFSET_BITS + DIV_QBITS;

	// input regs, front end (3, the last loads the dividers), divider steps, gain (2),
	// lane (3), output
	localparam int CLF_LATENCY     = 1 + 3 + DIV_QBITS + 2 + 3 + 1;

	localparam int Q30_BITS        = 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [7:0] TAYLOR_DIV [0:6] = '{8'd6, 8'd20, 8'd42, 8'd72,
		8'd110, 8'd156, 8'd210};

	localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(65536);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_CLIP_GAIN,
		REG_CLIP_LENGTH,
		REG_FADE_IN,
		REG_FADE_OUT,
		REG_XFADE_START,
		REG_INCOMING_GAIN,
		REG_XFADE_ENABLE
	} clf_reg_t;

	typedef struct packed {
		logic        [OFFSET_BITS-1:0] frame_offset;
		logic signed [SAMPLE_BITS-1:0] a_left;
		logic signed [SAMPLE_BITS-1:0] a_right;
		logic signed [SAMPLE_BITS-1:0] b_left;
		logic signed [SAMPLE_BITS-1:0] b_right;
	} clf_in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
	} clf_out_t;

	typedef struct packed {
		logic                          fi_act;
		logic                          fo_act;
		logic                          xf_zero;
		logic                          xf_full;
		logic signed [SAMPLE_BITS-1:0] a_left;
		logic signed [SAMPLE_BITS-1:0] a_right;
		logic signed [SAMPLE_BITS-1:0] b_left;
		logic signed [SAMPLE_BITS-1:0] b_right;
	} clf_side_t;

endpackage

`default_nettype wire

[design/clf_div.sv]
// ---------------------------------------------------------------------------
// clf_div
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// known to fit DIV_QBITS bits, so the partial remainder stays below the
// divisor and fits the divisor width.
// ---------------------------------------------------------------------------
`default_nettype none

module clf_div import clf_pkg::*; (
	input  wire logic                   clk,
	input  wire logic [DIV_IN_W-1:0]    dividend,
	input  wire logic [OFFSET_BITS-1:0] divisor,
	output logic      [DIV_QBITS-1:0]   quotient
);

	logic [OFFSET_BITS-1:0] rem_s [0:DIV_QBITS-1];
	logic [DIV_QBITS-1:0]   lq_s  [0:DIV_QBITS];

	assign rem_s[0] = dividend[DIV_IN_W-1:DIV_QBITS];
	assign lq_s[0]  = dividend[DIV_QBITS-1:0];

	for (genvar i = 0; i < DIV_QBITS; i++) begin : g_step
		logic [OFFSET_BITS:0] trial;
		logic [OFFSET_BITS:0] diff;
		logic                 fits;

		assign trial = {rem_s[i], lq_s[i][DIV_QBITS-1]};
		assign diff  = trial - {1'b0, divisor};
		assign fits  = trial >= {1'b0, divisor};

		always_ff @(posedge clk) begin
			lq_s[i+1] <= {lq_s[i][DIV_QBITS-2:0], fits};
		end

		if (i < DIV_QBITS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				rem_s[i+1] <= fits ? diff[OFFSET_BITS-1:0] : trial[OFFSET_BITS-1:0];
			end
		end
	end

	assign quotient = lq_s[DIV_QBITS];

endmodule

`default_nettype wire

[design/clf_gain.sv]
// ---------------------------------------------------------------------------
// clf_gain
// Turns fade ratios and the crossfade position into the two effective gains
// of a frame: fade-in and fade-out scaling, or cos/sin weights read from a
// quarter-wave sine ROM.
// ---------------------------------------------------------------------------
`default_nettype none

module clf_gain import clf_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 crossfade_enable,
	input  wire logic [GAIN_BITS-1:0] clip_gain,
	input  wire logic [GAIN_BITS-1:0] incoming_gain,
	input  wire logic [DIV_QBITS-1:0] ratio_in_s21,
	input  wire logic [DIV_QBITS-1:0] ratio_out_s21,
	input  wire logic [DIV_QBITS-1:0] ratio_x_s21,
	input  wire clf_side_t            side_s21,
	output logic      [GAIN_BITS-1:0] gain_a_s23,
	output logic      [GAIN_BITS-1:0] gain_b_s23,
	output clf_side_t                 side_s23
);

	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int ROM_W = TRIG_FRAC + 1;
	localparam int MUL_W = GAIN_BITS + ROM_W;
	localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(SINE_TABLE_DEPTH);

	typedef logic [ROM_W-1:0] rom_t [0:SINE_TABLE_DEPTH];

	function automatic rom_t build_rom();
		rom_t               tab;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        r;
		logic signed [63:0] sum;
		for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
			x    = (64'(k) * HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
			x2   = (x * x) >> Q30_BITS;
			term = x;
			sum  = $signed(x);
			for (int n = 1; n <= 7; n++) begin
				term = ((term * x2) >> Q30_BITS) / 64'(TAYLOR_DIV[n-1]);
				if (n[0]) begin
					sum = sum - $signed(term);
				end else begin
					sum = sum + $signed(term);
				end
			end
			if (sum < 0) begin
				sum = '0;
			end
			r = ($unsigned(sum) + (64'd1 << (Q30_BITS - TRIG_FRAC - 1)))
				>> (Q30_BITS - TRIG_FRAC);
			if (r > (64'd1 << TRIG_FRAC)) begin
				r = 64'd1 << TRIG_FRAC;
			end
			tab[k] = r[ROM_W-1:0];
		end
		return tab;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic [IDX_W-1:0]     idx;
	logic [IDX_W-1:0]     cos_addr;
	logic [MUL_W-1:0]     prod_fi;
	logic [GAIN_BITS-1:0] g1;

	logic [GAIN_BITS-1:0] g1_s22;
	logic [DIV_QBITS-1:0] ratio_out_s22;
	logic [ROM_W-1:0]     sin_s22;
	logic [ROM_W-1:0]     cos_s22;
	clf_side_t            side_s22;

	logic [MUL_W-1:0]     prod_fo;
	logic [MUL_W-1:0]     prod_a;
	logic [MUL_W-1:0]     prod_b;
	logic [GAIN_BITS-1:0] g2;

	always_comb begin
		if (side_s21.xf_zero) begin
			idx = '0;
		end else if (side_s21.xf_full || (ratio_x_s21 > DIV_QBITS'(SINE_TABLE_DEPTH))) begin
			idx = IDX_FULL;
		end else begin
			idx = ratio_x_s21[IDX_W-1:0];
		end
	end

	assign cos_addr = IDX_FULL - idx;
	assign prod_fi  = MUL_W'(clip_gain) * MUL_W'(ratio_in_s21);
	assign g1       = side_s21.fi_act ? prod_fi[TRIG_FRAC +: GAIN_BITS] : clip_gain;

	always_ff @(posedge clk) begin
		g1_s22        <= g1;
		ratio_out_s22 <= ratio_out_s21;
		sin_s22       <= SINE_ROM[idx];
		cos_s22       <= SINE_ROM[cos_addr];
		side_s22      <= side_s21;
	end

	assign prod_fo = MUL_W'(g1_s22) * MUL_W'(ratio_out_s22);
	assign prod_a  = MUL_W'(clip_gain) * MUL_W'(cos_s22);
	assign prod_b  = MUL_W'(incoming_gain) * MUL_W'(sin_s22);
	assign g2      = side_s22.fo_act ? prod_fo[TRIG_FRAC +: GAIN_BITS] : g1_s22;

	always_ff @(posedge clk) begin
		gain_a_s23 <= crossfade_enable ? prod_a[TRIG_FRAC +: GAIN_BITS] : g2;
		gain_b_s23 <= crossfade_enable ? prod_b[TRIG_FRAC +: GAIN_BITS] : '0;
		side_s23   <= side_s22;
	end

endmodule

`default_nettype wire

[design/clf_lane.sv]
// ---------------------------------------------------------------------------
// clf_lane
// One channel lane: weighted sum of the two samples, round to nearest with
// ties away from zero, saturate to the sample range.
// ---------------------------------------------------------------------------
`default_nettype none

module clf_lane import clf_pkg::*; (
	input  wire logic                          clk,
	input  wire logic signed [SAMPLE_BITS-1:0] a,
	input  wire logic signed [SAMPLE_BITS-1:0] b,
	input  wire logic        [GAIN_BITS-1:0]   gain_a,
	input  wire logic        [GAIN_BITS-1:0]   gain_b,
	output logic signed      [SAMPLE_BITS-1:0] sample
);

	localparam int PROD_W = SAMPLE_BITS + GAIN_BITS + 1;
	localparam int SUM_W  = PROD_W + 1;
	localparam int RND_W  = SUM_W - GAIN_FRAC_BITS;
	localparam logic [SUM_W-1:0] RND_HALF = SUM_W'(1) << (GAIN_FRAC_BITS - 1);
	localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [RND_W-1:0] SAT_LO = ~SAT_HI;

	logic signed [GAIN_BITS:0]   ga_sx;
	logic signed [GAIN_BITS:0]   gb_sx;
	logic signed [PROD_W-1:0]    pa_s24;
	logic signed [PROD_W-1:0]    pb_s24;
	logic signed [SUM_W-1:0]     sum_s25;
	logic        [SUM_W-1:0]     rnd_full;
	logic signed [RND_W-1:0]     rnd_s26;

	assign ga_sx = {1'b0, gain_a};
	assign gb_sx = {1'b0, gain_b};

	always_ff @(posedge clk) begin
		pa_s24 <= PROD_W'(a) * PROD_W'(ga_sx);
		pb_s24 <= PROD_W'(b) * PROD_W'(gb_sx);
	end

	always_ff @(posedge clk) begin
		sum_s25 <= SUM_W'(pa_s24) + SUM_W'(pb_s24);
	end

	assign rnd_full = $unsigned(sum_s25) + RND_HALF - SUM_W'(sum_s25[SUM_W-1]);

	always_ff @(posedge clk) begin
		rnd_s26 <= $signed(rnd_full[SUM_W-1:GAIN_FRAC_BITS]);
	end

	always_comb begin
		if (rnd_s26 > SAT_HI) begin
			sample = SAT_HI[SAMPLE_BITS-1:0];
		end else if (rnd_s26 < SAT_LO) begin
			sample = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			sample = rnd_s26[SAMPLE_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

[design/clip_fade_crossfade_gain.sv]
// ---------------------------------------------------------------------------
// clip_fade_crossfade_gain
// Clip gain for one stereo frame per transaction: linear fade-in and
// fade-out, or an equal-power crossfade between two clips.
//
//   channel   signals                          width       direction
//   command   start, busy, frame               1,1,128     in / out / in
//   result    done, result                     1,48        out
//   config    cfg_write, cfg_index, cfg_data   1,3,32      in
//
// One frame is taken every clock; busy stays low.
// From start to done a frame passes the input register, three front-end stages,
// 17 steps of the three dividers that run side by side, two gain stages, three
// lane stages and the output register; CLF_LATENCY counts this path.
// Reset clears the registers to their defaults and empties the pipeline.
// done is a one-cycle strobe; the receiver cannot hold results off.
// ---------------------------------------------------------------------------
`default_nettype none

module clip_fade_crossfade_gain import clf_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire clf_in_t                  frame,
	output logic                          done,
	output clf_out_t                      result,
	input  wire logic                     cfg_write,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

	logic [GAIN_BITS-1:0]   clip_gain_q;
	logic [OFFSET_BITS-1:0] clip_length_q;
	logic [OFFSET_BITS-1:0] fade_in_q;
	logic [OFFSET_BITS-1:0] fade_out_q;
	logic [OFFSET_BITS-1:0] xfade_start_q;
	logic [GAIN_BITS-1:0]   incoming_gain_q;
	logic                   xfade_enable_q;
	logic [OFFSET_BITS-1:0] den_q;

	logic [CLF_LATENCY-1:0] vld_q;
	logic                   accept;

	clf_in_t                frame_s1;

	logic [OFFSET_BITS-1:0] off_s2;
	logic [OFFSET_BITS-1:0] rem_s2;
	logic [OFFSET_BITS-1:0] num_s2;
	logic                   len_gt_off_s2;
	logic                   off_gt_xs_s2;
	logic                   fi_act_s2;
	clf_in_t                frame_s2;

	logic [OFFSET_BITS-1:0] off_s3;
	logic [OFFSET_BITS-1:0] rem_s3;
	logic [DIV_IN_W-1:0]    nprod_s3;
	clf_side_t              side_s3;

	logic [DIV_IN_W-1:0]    dvin_in_s4;
	logic [DIV_IN_W-1:0]    dvin_out_s4;
	logic [DIV_IN_W-1:0]    dvin_x_s4;
	clf_side_t              side_s4;
	clf_side_t              side_pipe_s [0:DIV_QBITS-1];

	logic [DIV_QBITS-1:0]   ratio_in_s21;
	logic [DIV_QBITS-1:0]   ratio_out_s21;
	logic [DIV_QBITS-1:0]   ratio_x_s21;

	logic [GAIN_BITS-1:0]   gain_a_s23;
	logic [GAIN_BITS-1:0]   gain_b_s23;
	clf_side_t              side_s23;

	logic signed [SAMPLE_BITS-1:0] left_lane;
	logic signed [SAMPLE_BITS-1:0] right_lane;
	clf_out_t                      result_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_gain_q     <= GAIN_UNITY;
			clip_length_q   <= '0;
			fade_in_q       <= '0;
			fade_out_q      <= '0;
			xfade_start_q   <= '0;
			incoming_gain_q <= GAIN_UNITY;
			xfade_enable_q  <= 1'b0;
		end else if (cfg_write) begin
			case (clf_reg_t'(cfg_index))
				REG_CLIP_GAIN:     clip_gain_q     <= cfg_data[GAIN_BITS-1:0];
				REG_CLIP_LENGTH:   clip_length_q   <= cfg_data[OFFSET_BITS-1:0];
				REG_FADE_IN:       fade_in_q       <= cfg_data[OFFSET_BITS-1:0];
				REG_FADE_OUT:      fade_out_q      <= cfg_data[OFFSET_BITS-1:0];
				REG_XFADE_START:   xfade_start_q   <= cfg_data[OFFSET_BITS-1:0];
				REG_INCOMING_GAIN: incoming_gain_q <= cfg_data[GAIN_BITS-1:0];
				REG_XFADE_ENABLE:  xfade_enable_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// crossfade span, at least one frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_q <= OFFSET_BITS'(1);
		end else begin
			den_q <= (clip_length_q > xfade_start_q) ? clip_length_q - xfade_start_q
				: OFFSET_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[CLF_LATENCY-2:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		frame_s1 <= frame;
	end

	always_ff @(posedge clk) begin
		off_s2        <= frame_s1.frame_offset;
		rem_s2        <= clip_length_q - frame_s1.frame_offset;
		num_s2        <= frame_s1.frame_offset - xfade_start_q;
		len_gt_off_s2 <= frame_s1.frame_offset < clip_length_q;
		off_gt_xs_s2  <= frame_s1.frame_offset > xfade_start_q;
		fi_act_s2     <= frame_s1.frame_offset < fade_in_q;
		frame_s2      <= frame_s1;
	end

	always_ff @(posedge clk) begin
		off_s3          <= off_s2;
		rem_s3          <= rem_s2;
		nprod_s3        <= DIV_IN_W'(num_s2) * DIV_IN_W'(SINE_TABLE_DEPTH);
		side_s3.fi_act  <= fi_act_s2;
		side_s3.fo_act  <= len_gt_off_s2 && (rem_s2 <= fade_out_q);
		side_s3.xf_zero <= !off_gt_xs_s2;
		side_s3.xf_full <= num_s2 >= den_q;
		side_s3.a_left  <= frame_s2.a_left;
		side_s3.a_right <= frame_s2.a_right;
		side_s3.b_left  <= frame_s2.b_left;
		side_s3.b_right <= frame_s2.b_right;
	end

	always_ff @(posedge clk) begin
		dvin_in_s4  <= DIV_IN_W'({off_s3, TRIG_FRAC'(0)});
		dvin_out_s4 <= DIV_IN_W'({rem_s3, TRIG_FRAC'(0)});
		dvin_x_s4   <= nprod_s3 + DIV_IN_W'(den_q >> 1);
		side_s4     <= side_s3;
	end

	always_ff @(posedge clk) begin
		side_pipe_s[0] <= side_s4;
		for (int i = 1; i < DIV_QBITS; i++) begin
			side_pipe_s[i] <= side_pipe_s[i-1];
		end
	end

	clf_div u_div_in (
		.clk      (clk),
		.dividend (dvin_in_s4),
		.divisor  (fade_in_q),
		.quotient (ratio_in_s21)
	);

	clf_div u_div_out (
		.clk      (clk),
		.dividend (dvin_out_s4),
		.divisor  (fade_out_q),
		.quotient (ratio_out_s21)
	);

	clf_div u_div_x (
		.clk      (clk),
		.dividend (dvin_x_s4),
		.divisor  (den_q),
		.quotient (ratio_x_s21)
	);

	clf_gain #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_gain (
		.clk              (clk),
		.crossfade_enable (xfade_enable_q),
		.clip_gain        (clip_gain_q),
		.incoming_gain    (incoming_gain_q),
		.ratio_in_s21     (ratio_in_s21),
		.ratio_out_s21    (ratio_out_s21),
		.ratio_x_s21      (ratio_x_s21),
		.side_s21         (side_pipe_s[DIV_QBITS-1]),
		.gain_a_s23       (gain_a_s23),
		.gain_b_s23       (gain_b_s23),
		.side_s23         (side_s23)
	);

	clf_lane u_lane_left (
		.clk    (clk),
		.a      (side_s23.a_left),
		.b      (side_s23.b_left),
		.gain_a (gain_a_s23),
		.gain_b (gain_b_s23),
		.sample (left_lane)
	);

	clf_lane u_lane_right (
		.clk    (clk),
		.a      (side_s23.a_right),
		.b      (side_s23.b_right),
		.gain_a (gain_a_s23),
		.gain_b (gain_b_s23),
		.sample (right_lane)
	);

	// merge the lanes into one transaction
	always_ff @(posedge clk) begin
		result_q.left_out  <= left_lane;
		result_q.right_out <= right_lane;
	end

	assign result = result_q;
	assign done   = vld_q[CLF_LATENCY-1];

endmodule

`default_nettype wire

[design/clf_check.sv]
// ---------------------------------------------------------------------------
// clf_check
// Port-level checks of the clip fade / crossfade gain block: result timing,
// silence in gives silence out, and matched channels give matched results.
// ---------------------------------------------------------------------------
`default_nettype none

module clf_check import clf_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic                     busy,
	input  wire clf_in_t                  frame,
	input  wire logic                     done,
	input  wire clf_out_t                 result,
	input  wire logic                     cfg_write,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int AGE_W = $clog2(CLF_LATENCY + 1);
	localparam logic [AGE_W-1:0] AGE_FULL = AGE_W'(CLF_LATENCY);

	logic [AGE_W-1:0] age_q;
	logic             settled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (age_q != AGE_FULL) begin
			age_q <= age_q + AGE_W'(1);
		end
	end

	assign settled = age_q == AGE_FULL;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		settled |-> (done == $past(start && !busy, CLF_LATENCY)))
		else $error("done does not follow the accepted transaction");

	a_silence: assert property (@(posedge clk) disable iff (!arst_n)
		(settled && done && $past(frame.a_left == 0 && frame.a_right == 0 &&
			frame.b_left == 0 && frame.b_right == 0, CLF_LATENCY))
		|-> (result.left_out == 0 && result.right_out == 0))
		else $error("silent frame produced a nonzero result");

	a_match: assert property (@(posedge clk) disable iff (!arst_n)
		(settled && done && $past(frame.a_left == frame.a_right &&
			frame.b_left == frame.b_right, CLF_LATENCY))
		|-> (result.left_out == result.right_out))
		else $error("matched channels produced different results");

	logic unused_cfg;
	assign unused_cfg = cfg_write ^ (^cfg_index) ^ (^cfg_data);

endmodule

bind clip_fade_crossfade_gain clf_check u_check (.*);

`default_nettype wire
